// File: design/cfir_pkg.sv
package cfir_pkg;

  localparam int unsigned MAX_TAPS    = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned OUT_BITS    = 39;
  localparam int unsigned IDX_W       = $clog2(MAX_TAPS);
  localparam int unsigned TC_W        = $clog2(MAX_TAPS + 1);
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;
  localparam int unsigned COEF_W      = 2 * SAMPLE_BITS;
  localparam int unsigned CFG_W       = TC_W;
  localparam int unsigned CFG_IDX_W   = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_COMPLEX_COEFS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_TAP_COUNT     = cfg_idx_t'(1);

  // input word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  localparam logic [TC_W-1:0] TAP_COUNT_RESET = TC_W'(MAX_TAPS);

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  // taps actually in use: zero means one, anything above the maximum clips
  function automatic logic [TC_W-1:0] taps_in_use(input logic [TC_W-1:0] tc);
    logic [TC_W-1:0] n;
    if (tc == '0) begin
      n = TC_W'(1);
    end else if (tc > TC_W'(MAX_TAPS)) begin
      n = TC_W'(MAX_TAPS);
    end else begin
      n = tc;
    end
    return n;
  endfunction

endpackage

// File: design/cfir_if.sv
interface cfir_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       kind;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0]    sample_re;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0]    sample_im;
  logic        [cfir_pkg::IDX_W-1:0]          coef_index;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0]    coef_re;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0]    coef_im;

  modport source (
    output valid, kind, sample_re, sample_im, coef_index, coef_re, coef_im,
    input  ready
  );
  modport sink (
    input  valid, kind, sample_re, sample_im, coef_index, coef_re, coef_im,
    output ready
  );
endinterface

interface cfir_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cfir_pkg::OUT_BITS-1:0]    out_re;
  logic signed [cfir_pkg::OUT_BITS-1:0]    out_im;

  modport source (
    output valid, out_re, out_im,
    input  ready
  );
  modport sink (
    input  valid, out_re, out_im,
    output ready
  );
endinterface

// File: design/cfir_ram.sv
module cfir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/cfir_cell.sv
// one delay line entry, loaded from the input or from its neighbor in the ring
module cfir_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    load_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] load_re_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] load_im_i,
  input  logic                                    shift_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] nb_re_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] nb_im_i,
  output logic signed [cfir_pkg::SAMPLE_BITS-1:0] re_o,
  output logic signed [cfir_pkg::SAMPLE_BITS-1:0] im_o
);

  logic signed [cfir_pkg::SAMPLE_BITS-1:0] re_q, im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= '0;
      im_q <= '0;
    end else if (load_i) begin
      re_q <= load_re_i;
      im_q <= load_im_i;
    end else if (shift_i) begin
      re_q <= nb_re_i;
      im_q <= nb_im_i;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

// File: design/cfir_mac.sv
// complex multiply, registered, then accumulate
module cfir_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cfir_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_re_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_im_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] c_re_i,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] c_im_i,
  output logic                                    busy_o,
  output logic signed [cfir_pkg::OUT_BITS-1:0]    acc_re_o,
  output logic signed [cfir_pkg::OUT_BITS-1:0]    acc_im_o
);

  logic                                   pv_q;
  logic signed [cfir_pkg::PROD_W-1:0]     prr_q, pii_q, pri_q, pir_q;
  logic signed [cfir_pkg::OUT_BITS-1:0]   acc_re_q, acc_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prr_q <= x_re_i * c_re_i;
    pii_q <= x_im_i * c_im_i;
    pri_q <= x_re_i * c_im_i;
    pir_q <= x_im_i * c_re_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (pv_q) begin
      acc_re_q <= acc_re_q + cfir_pkg::OUT_BITS'(prr_q) - cfir_pkg::OUT_BITS'(pii_q);
      acc_im_q <= acc_im_q + cfir_pkg::OUT_BITS'(pri_q) + cfir_pkg::OUT_BITS'(pir_q);
    end
  end

  assign busy_o   = pv_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

// File: design/complex_fir_filter.sv
// complex fir filter, q1.15 samples and coefficients, exact q9.30 sums
//
// in_i carries one word per handshake: kind selects a sample to filter or a
// coefficient write (coef_index, coef_re, coef_im). out_o gives one
// word per sample with the full accumulator; coefficient writes give none.
// cfg_we_i/cfg_idx_i/cfg_data_i write complex_coefs (0) and tap_count (1);
// the user must write them only while the filter is idle; the block does not enforce it.
//
// a coefficient write leaves the input open, and the next word is taken right after.
// a sample with n taps in use is accepted, the ring of delay cells then
// rotates n steps, once per cycle, past a single complex mac, and the
// result goes to the output register once the mac has drained and that
// register is free; the input reopens as the result appears, so a new
// sample is taken only after the previous run has finished.
//
// reset clears the delay line, the write pointer and the coefficient valid
// bits (unwritten coefficients read as zero) and restores the registers.
// a stalled receiver holds the result word; the next sample is still
// accepted and computed, and waits at the end of its run until the output
// register is free.
module complex_fir_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  cfir_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [cfir_pkg::CFG_W-1:0]     cfg_data_i,
  cfir_in_if.sink                        in_i,
  cfir_out_if.source                     out_o
);

  localparam int unsigned MAX_TAPS = cfir_pkg::MAX_TAPS;
  localparam int unsigned SB       = cfir_pkg::SAMPLE_BITS;
  localparam int unsigned IDX_W    = cfir_pkg::IDX_W;
  localparam int unsigned TC_W     = cfir_pkg::TC_W;
  localparam int unsigned COEF_W   = cfir_pkg::COEF_W;
  localparam int unsigned OB       = cfir_pkg::OUT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e state_q;

  // configuration
  logic            complex_q;
  logic [TC_W-1:0] tc_q;

  // sequencing
  logic [IDX_W-1:0]  wp_q;       // delay write pointer
  logic [IDX_W-1:0]  k_q;        // coefficient index of the current step
  logic [IDX_W-1:0]  t_q;        // step count within the run
  logic [MAX_TAPS-1:0] cvalid_q; // coefficient slot written since reset

  // first pipeline stage: delay head and coefficient read, aligned
  logic                 v1_q;
  logic                 cok_q;
  logic signed [SB-1:0] head_re_q, head_im_q;

  // output register
  logic                 out_valid_q;
  logic signed [OB-1:0] out_re_q, out_im_q;

  logic [TC_W-1:0]  n, n_m1;
  logic [IDX_W-1:0] p_old, p_new, k0, k_d;
  logic [TC_W-1:0]  p_inc, k_inc;
  logic             acc_in, acc_sample, acc_coef, issue, last_step, finish;
  logic             mac_busy;
  logic [COEF_W-1:0] coef_rdata;
  logic signed [SB-1:0] c_re, c_im;
  logic signed [OB-1:0] acc_re, acc_im;
  cfir_pkg::mac_ctrl_t  mac_ctrl;

  logic signed [SB-1:0] cell_re [MAX_TAPS];
  logic signed [SB-1:0] cell_im [MAX_TAPS];

  assign n    = cfir_pkg::taps_in_use(tc_q);
  assign n_m1 = n - TC_W'(1);

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc_in     = in_i.valid && in_i.ready;
  assign acc_sample = acc_in && (in_i.kind == cfir_pkg::KIND_SAMPLE);
  assign acc_coef   = acc_in && (in_i.kind == cfir_pkg::KIND_COEF);

  assign issue     = (state_q == ST_RUN);
  assign last_step = ({1'b0, t_q} == n_m1);
  assign finish    = (state_q == ST_DRAIN) && !v1_q && !mac_busy &&
                     (!out_valid_q || out_o.ready);

  // pointer handling: a pointer left beyond a shrunk ring restarts at entry 0
  always_comb begin
    p_old = ({1'b0, wp_q} >= n) ? '0 : wp_q;
    p_inc = {1'b0, p_old} + TC_W'(1);
    p_new = (p_inc >= n) ? '0 : p_inc[IDX_W-1:0];
    // the oldest sample sits at p_new and takes coefficient 0
    k0    = (p_new == '0) ? '0 : IDX_W'(n - {1'b0, p_new});
    k_inc = {1'b0, k_q} + TC_W'(1);
    k_d   = (k_inc >= n) ? '0 : k_inc[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      complex_q   <= 1'b0;
      tc_q        <= cfir_pkg::TAP_COUNT_RESET;
      wp_q        <= '0;
      k_q         <= '0;
      t_q         <= '0;
      cvalid_q    <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfir_pkg::CFG_COMPLEX_COEFS: complex_q <= cfg_data_i[0];
          cfir_pkg::CFG_TAP_COUNT:     tc_q      <= cfg_data_i[TC_W-1:0];
          default: ;
        endcase
      end

      if (acc_coef) begin
        cvalid_q[in_i.coef_index] <= 1'b1;
      end

      v1_q <= issue;

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (acc_sample) begin
            wp_q    <= p_new;
            k_q     <= k0;
            t_q     <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          k_q <= k_d;
          t_q <= t_q + IDX_W'(1);
          if (last_step) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // head of the ring and coefficient valid bit, lined up with the ram read
  always_ff @(posedge clk_i) begin
    head_re_q <= cell_re[0];
    head_im_q <= cell_im[0];
    cok_q     <= cvalid_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_re_q <= acc_re;
      out_im_q <= acc_im;
    end
  end

  // coefficient store, {re, im} per slot
  cfir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (acc_coef),
    .waddr_i (in_i.coef_index),
    .wdata_i ({in_i.coef_re, in_i.coef_im}),
    .raddr_i (k_q),
    .rdata_o (coef_rdata)
  );

  // unwritten slots read as zero; real mode drops the imaginary part
  assign c_re = cok_q ? $signed(coef_rdata[COEF_W-1:SB]) : '0;
  assign c_im = (cok_q && complex_q) ? $signed(coef_rdata[SB-1:0]) : '0;

  // delay ring: cells below n rotate toward cell 0, cell n-1 takes cell 0,
  // so after n steps every entry is back in its own cell
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [SB-1:0] nb_re, nb_im;

    if (i == MAX_TAPS - 1) begin : g_end
      assign nb_re = cell_re[0];
      assign nb_im = cell_im[0];
    end else begin : g_mid
      assign nb_re = (TC_W'(i) == n_m1) ? cell_re[0] : cell_re[i+1];
      assign nb_im = (TC_W'(i) == n_m1) ? cell_im[0] : cell_im[i+1];
    end

    cfir_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .load_i    (acc_sample && (p_old == IDX_W'(i))),
      .load_re_i (in_i.sample_re),
      .load_im_i (in_i.sample_im),
      .shift_i   (issue && (TC_W'(i) < n)),
      .nb_re_i   (nb_re),
      .nb_im_i   (nb_im),
      .re_o      (cell_re[i]),
      .im_o      (cell_im[i])
    );
  end

  assign mac_ctrl.clear = acc_sample;
  assign mac_ctrl.valid = v1_q;

  cfir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .x_re_i   (head_re_q),
    .x_im_i   (head_im_q),
    .c_re_i   (c_re),
    .c_im_i   (c_im),
    .busy_o   (mac_busy),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.out_re = out_re_q;
  assign out_o.out_im = out_im_q;

endmodule

// File: design/cfir_checker.sv
module cfir_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  in_kind_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [cfir_pkg::OUT_BITS-1:0]  out_re_i
);

  // a coefficient write never blocks the next word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == cfir_pkg::KIND_COEF) |=> in_ready_i)
    else $error("input blocked after coefficient write");

  // a sample closes the input in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == cfir_pkg::KIND_SAMPLE) |=> !in_ready_i)
    else $error("input taken during a sample run");

  // a new result appears only as its run ends and the input reopens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result appeared while a run is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_re_i))
    else $error("result changed while stalled");

endmodule

bind complex_fir_filter cfir_checker u_cfir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_re_i    (out_o.out_re)
);
